// File: sv/http_response_header_parser_core_macros.svh
// Assertion macros used by the parser core module.
`ifndef HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HRP_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Implication whose consequent is checked in the cycle after.
`define HRP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: sv/hrp_pkg.sv
package hrp_pkg;

  typedef enum logic [3:0] {
    PH_START        = 4'd0,
    PH_MAJOR_START  = 4'd1,
    PH_MAJOR        = 4'd2,
    PH_MINOR_START  = 4'd3,
    PH_MINOR        = 4'd4,
    PH_STATUS_START = 4'd5,
    PH_STATUS       = 4'd6,
    PH_REASON_START = 4'd7,
    PH_REASON       = 4'd8,
    PH_LINE_LF      = 4'd9,
    PH_NAME         = 4'd10,
    PH_SKIPSP       = 4'd11,
    PH_CONTENT      = 4'd12,
    PH_BODY_LF      = 4'd13,
    PH_BODY         = 4'd14,
    PH_ERROR        = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CONSUMED = 3'd0,
    KIND_CONTENT  = 3'd1,
    KIND_HDR_END  = 3'd2,
    KIND_BODY     = 3'd3,
    KIND_DONE     = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChDot   = 8'h2e;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  field_code;
    logic [7:0]  data_byte;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
    logic [15:0] status_value;
  } result_t;

  typedef struct packed {
    logic [4:0] node;
    logic [4:0] offset;
    logic       mismatch;
  } trie_state_t;

  // Expected character of the lower-case "http/" prefix at a position.
  function automatic logic [7:0] prefix_char(input logic [2:0] i);
    case (i)
      3'd0:    prefix_char = "h";
      3'd1:    prefix_char = "t";
      3'd2:    prefix_char = "t";
      3'd3:    prefix_char = "p";
      3'd4:    prefix_char = "/";
      default: prefix_char = 8'h00;
    endcase
  endfunction

  // Node text character at an offset (0 when beyond text).
  function automatic logic [7:0] node_char(input logic [4:0] n, input logic [4:0] o);
    string s;
    begin
      case (n)
        5'd1:  s = "a";
        5'd2:  s = "date";
        5'd3:  s = "c";
        5'd4:  s = "expires";
        5'd5:  s = "last-modified";
        5'd6:  s = "pragma";
        5'd7:  s = "se";
        5'd8:  s = "transfer-encoding";
        5'd9:  s = "vary";
        5'd10: s = "warning";
        5'd11: s = "ccept-ranges";
        5'd12: s = "ge";
        5'd13: s = "llow";
        5'd14: s = "ache-control";
        5'd15: s = "on";
        5'd16: s = "rver";
        5'd17: s = "t-cookie";
        5'd18: s = "nection";
        5'd19: s = "tent-";
        5'd20: s = "encoding";
        5'd21: s = "l";
        5'd22: s = "md5";
        5'd23: s = "range";
        5'd24: s = "type";
        5'd25: s = "anguage";
        5'd26: s = "ength";
        5'd27: s = "ocation";
        default: s = "";
      endcase
      node_char = (int'(o) < s.len()) ? s[o] : 8'h00;
    end
  endfunction

  function automatic logic [4:0] node_len(input logic [4:0] n);
    case (n)
      5'd1, 5'd3, 5'd21:                         node_len = 5'd1;
      5'd7, 5'd12, 5'd15:                        node_len = 5'd2;
      5'd22:                                     node_len = 5'd3;
      5'd2, 5'd9, 5'd13, 5'd16, 5'd24:           node_len = 5'd4;
      5'd19, 5'd23, 5'd26:                       node_len = 5'd5;
      5'd6:                                      node_len = 5'd6;
      5'd4, 5'd10, 5'd18, 5'd25, 5'd27:          node_len = 5'd7;
      5'd17, 5'd20:                              node_len = 5'd8;
      5'd11, 5'd14:                              node_len = 5'd12;
      5'd5:                                      node_len = 5'd13;
      5'd8:                                      node_len = 5'd17;
      default:                                   node_len = 5'd0;
    endcase
  endfunction

  function automatic logic [4:0] node_code(input logic [4:0] n);
    case (n)
      5'd2:  node_code = 5'd13;
      5'd4:  node_code = 5'd14;
      5'd5:  node_code = 5'd15;
      5'd6:  node_code = 5'd16;
      5'd8:  node_code = 5'd19;
      5'd9:  node_code = 5'd20;
      5'd10: node_code = 5'd21;
      5'd11: node_code = 5'd1;
      5'd12: node_code = 5'd2;
      5'd13: node_code = 5'd3;
      5'd14: node_code = 5'd4;
      5'd16: node_code = 5'd17;
      5'd17: node_code = 5'd18;
      5'd18: node_code = 5'd5;
      5'd20: node_code = 5'd6;
      5'd22: node_code = 5'd10;
      5'd23: node_code = 5'd11;
      5'd24: node_code = 5'd12;
      5'd25: node_code = 5'd7;
      5'd26: node_code = 5'd8;
      5'd27: node_code = 5'd9;
      default: node_code = 5'd0;
    endcase
  endfunction

  // Child of a node selected by its first character; 0 means none.
  function automatic logic [4:0] node_child(input logic [4:0] n, input logic [7:0] ch);
    logic [4:0] r;
    begin
      r = 5'd0;
      case (n)
        5'd0: begin
          case (ch)
            "a": r = 5'd1;
            "d": r = 5'd2;
            "c": r = 5'd3;
            "e": r = 5'd4;
            "l": r = 5'd5;
            "p": r = 5'd6;
            "s": r = 5'd7;
            "t": r = 5'd8;
            "v": r = 5'd9;
            "w": r = 5'd10;
            default: r = 5'd0;
          endcase
        end
        5'd1: begin
          case (ch)
            "c": r = 5'd11;
            "g": r = 5'd12;
            "l": r = 5'd13;
            default: r = 5'd0;
          endcase
        end
        5'd3: begin
          case (ch)
            "a": r = 5'd14;
            "o": r = 5'd15;
            default: r = 5'd0;
          endcase
        end
        5'd7: begin
          case (ch)
            "r": r = 5'd16;
            "t": r = 5'd17;
            default: r = 5'd0;
          endcase
        end
        5'd15: begin
          case (ch)
            "n": r = 5'd18;
            "t": r = 5'd19;
            default: r = 5'd0;
          endcase
        end
        5'd19: begin
          case (ch)
            "e": r = 5'd20;
            "l": r = 5'd21;
            "m": r = 5'd22;
            "r": r = 5'd23;
            "t": r = 5'd24;
            default: r = 5'd0;
          endcase
        end
        5'd21: begin
          case (ch)
            "a": r = 5'd25;
            "e": r = 5'd26;
            "o": r = 5'd27;
            default: r = 5'd0;
          endcase
        end
        default: r = 5'd0;
      endcase
      node_child = r;
    end
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b);
    fold = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
  endfunction

endpackage

// File: sv/hrp_stream_if.sv
interface hrp_stream_if #(parameter int Width = 8);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/http_response_header_parser_core.sv
// Channel | Direction | Payload
// in      | sink      | byte_in (8 bits)
// out     | source    | result_t: kind, field_code, data_byte, versions, status
//
// One byte is taken every cycle while the output is not stalled; each result appears
// in the cycle after its byte. The single result register is the only stage.
// A stalled output holds the result and stops input only while it is full
// and not taken. Reset (rst, synchronous) returns the parser to the start.
`include "http_response_header_parser_core_macros.svh"

module http_response_header_parser_core
  import hrp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  hrp_stream_if.sink   in_ch,
  hrp_stream_if.source out_ch
);

  phase_t      phase, phase_next;
  logic [2:0]  prefix_index, prefix_index_next;
  trie_state_t trie, trie_next, trie_adv;
  logic [4:0]  current_field, current_field_next;
  logic [7:0]  major_reg, major_next;
  logic [7:0]  minor_reg, minor_next;
  logic [15:0] status_reg, status_next;
  logic        out_valid;
  result_t     result, res_next;
  logic        take;

  logic [7:0]  b;
  logic [7:0]  fb;
  logic        digit, alpha;
  logic [3:0]  dval;
  logic [11:0] maj_acc, min_acc;
  logic [19:0] st_acc;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = result;

  assign b     = in_ch.data;
  assign fb    = fold(b);
  assign digit = b >= "0" && b <= "9";
  assign alpha = (b | 8'h20) >= "a" && (b | 8'h20) <= "z";
  assign dval  = b[3:0];

  hrp_trie u_trie (.cur(trie), .ch(fb), .nxt(trie_adv));

  // Decimal accumulation, saturating.
  always_comb begin
    maj_acc = ((phase == PH_MAJOR) ? {4'd0, major_reg} * 12'd10 : 12'd0) + {8'd0, dval};
    min_acc = ((phase == PH_MINOR) ? {4'd0, minor_reg} * 12'd10 : 12'd0) + {8'd0, dval};
    st_acc  = ((phase == PH_STATUS) ? {4'd0, status_reg} * 20'd10 : 20'd0) + {16'd0, dval};
  end

  // Next state and result for the incoming byte.
  always_comb begin
    logic bad;
    logic [4:0] fc;
    logic [7:0] db;
    logic [2:0] kind;
    bad = 1'b0;
    fc = 5'd0;
    db = 8'd0;
    kind = KIND_CONSUMED;
    phase_next = phase;
    prefix_index_next = prefix_index;
    trie_next = trie;
    current_field_next = current_field;
    major_next = major_reg;
    minor_next = minor_reg;
    status_next = status_reg;
    if (b == 8'd0) begin
      kind = (phase == PH_BODY || phase == PH_ERROR) ? KIND_DONE : KIND_ERROR;
    end else begin
      case (phase)
        PH_START: begin
          if (prefix_index < 3'd5 && fb == prefix_char(prefix_index)) begin
            if (prefix_index == 3'd4) begin
              prefix_index_next = 3'd0;
              phase_next = PH_MAJOR_START;
            end else begin
              prefix_index_next = prefix_index + 3'd1;
            end
          end else begin
            bad = 1'b1;
          end
        end
        PH_MAJOR_START, PH_MAJOR: begin
          if (digit) begin
            major_next = (maj_acc > 12'd255) ? 8'd255 : maj_acc[7:0];
            phase_next = PH_MAJOR;
          end else if (b == ChDot && phase == PH_MAJOR) begin
            phase_next = PH_MINOR_START;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MINOR_START, PH_MINOR: begin
          if (digit) begin
            minor_next = (min_acc > 12'd255) ? 8'd255 : min_acc[7:0];
            phase_next = PH_MINOR;
          end else if (b == ChSpace && phase == PH_MINOR) begin
            phase_next = PH_STATUS_START;
          end else begin
            bad = 1'b1;
          end
        end
        PH_STATUS_START, PH_STATUS: begin
          if (digit) begin
            status_next = (st_acc > 20'd65535) ? 16'hffff : st_acc[15:0];
            phase_next = PH_STATUS;
          end else if (b == ChSpace && phase == PH_STATUS) begin
            phase_next = PH_REASON_START;
          end else begin
            bad = 1'b1;
          end
        end
        PH_REASON_START: begin
          if (alpha) phase_next = PH_REASON;
          else bad = 1'b1;
        end
        PH_REASON: begin
          if (b == ChCr) phase_next = PH_LINE_LF;
          else if (!(alpha || b == ChSpace || b == ChDash)) bad = 1'b1;
        end
        PH_LINE_LF: begin
          if (b == ChLf) begin
            trie_next = '0;
            current_field_next = 5'd0;
            phase_next = PH_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        PH_NAME: begin
          if (b == ChCr) begin
            phase_next = (trie.node == 5'd0 && !trie.mismatch) ? PH_BODY_LF : PH_LINE_LF;
          end else if (b == ChColon) begin
            if (!trie.mismatch && node_code(trie.node) != 5'd0 &&
                trie.offset == node_len(trie.node)) begin
              current_field_next = node_code(trie.node);
              phase_next = PH_SKIPSP;
            end else begin
              current_field_next = 5'd0;
              phase_next = PH_CONTENT;
            end
          end else begin
            trie_next = trie_adv;
          end
        end
        PH_SKIPSP, PH_CONTENT: begin
          if (phase == PH_SKIPSP && b == ChSpace) begin
            phase_next = PH_CONTENT;
          end else if (b == ChCr) begin
            phase_next = PH_LINE_LF;
            if (current_field != 5'd0) begin
              fc = current_field;
              kind = KIND_HDR_END;
            end
          end else begin
            phase_next = PH_CONTENT;
            if (current_field != 5'd0) begin
              fc = current_field;
              db = b;
              kind = KIND_CONTENT;
            end
          end
        end
        PH_BODY_LF: begin
          if (b == ChLf) phase_next = PH_BODY;
          else bad = 1'b1;
        end
        PH_BODY: begin
          kind = KIND_BODY;
          db = b;
        end
        default: begin
        end
      endcase
      if (bad) begin
        kind = KIND_ERROR;
        phase_next = PH_ERROR;
      end
    end
    res_next = '{kind: kind, field_code: fc, data_byte: db, ver_major: major_next,
                 ver_minor: minor_next, status_value: status_next};
    // Byte zero returns everything to reset after reporting.
    if (b == 8'd0) begin
      phase_next = PH_START;
      prefix_index_next = 3'd0;
      trie_next = '0;
      current_field_next = 5'd0;
      major_next = 8'd0;
      minor_next = 8'd0;
      status_next = 16'd0;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      prefix_index <= 3'd0;
      trie <= '0;
      current_field <= 5'd0;
      major_reg <= 8'd0;
      minor_reg <= 8'd0;
      status_reg <= 16'd0;
    end else if (take) begin
      phase <= phase_next;
      prefix_index <= prefix_index_next;
      trie <= trie_next;
      current_field <= current_field_next;
      major_reg <= major_next;
      minor_reg <= minor_next;
      status_reg <= status_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

  `HRP_ASSERT_NEXT(a_zero_resets, clk, rst, take && b == 8'd0, phase == PH_START,
    "byte zero did not return the parser to start")
  `HRP_ASSERT_NEXT(a_take_valid, clk, rst, take, out_valid, "accepted byte gave no result")
  `HRP_ASSERT_IMP(a_field_kind, clk, rst,
    out_valid && (result.kind == KIND_CONTENT || result.kind == KIND_HDR_END),
    result.field_code != 5'd0, "known header result without a field")
  `HRP_ASSERT_IMP(a_prefix_range, clk, rst, 1'b1, prefix_index <= 3'd4,
    "prefix index beyond the prefix length")

endmodule

// File: sv/hrp_trie.sv
module hrp_trie
  import hrp_pkg::*;
(
  input  trie_state_t cur,
  input  logic [7:0]  ch,
  output trie_state_t nxt
);

  logic [4:0] len;
  logic [4:0] child;

  assign len   = node_len(cur.node);
  assign child = node_child(cur.node, ch);

  // Advance the name match by one folded byte.
  always_comb begin
    nxt = cur;
    if (cur.mismatch) begin
      nxt.mismatch = 1'b1;
    end else if (cur.offset < len) begin
      if (node_char(cur.node, cur.offset) == ch) begin
        nxt.offset = cur.offset + 5'd1;
      end else begin
        nxt.mismatch = 1'b1;
      end
    end else if (child != 5'd0) begin
      nxt.node   = child;
      nxt.offset = 5'd1;
    end else begin
      nxt.mismatch = 1'b1;
    end
  end

endmodule

// File: verif/tb_http_response_header_parser_core.sv
module tb_http_response_header_parser_core;
  import hrp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrp_stream_if #(.Width(8)) in_ch ();
  hrp_stream_if #(.Width($bits(result_t))) out_ch ();

  http_response_header_parser_core dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Header name trie: node text, code, first child and child count.
  string name_txt [28] = '{"", "a", "date", "c", "expires", "last-modified", "pragma", "se",
    "transfer-encoding", "vary", "warning", "ccept-ranges", "ge", "llow", "ache-control", "on",
    "rver", "t-cookie", "nection", "tent-", "encoding", "l", "md5", "range", "type", "anguage",
    "ength", "ocation"};
  int name_code [28] = '{0, 0, 13, 0, 14, 15, 16, 0, 19, 20, 21, 1, 2, 3, 4, 0, 17, 18, 5, 0,
    6, 0, 10, 11, 12, 7, 8, 9};
  int name_first [28] = '{1, 11, 0, 14, 0, 0, 0, 16, 0, 0, 0, 0, 0, 0, 0, 18, 0, 0, 0, 20,
    0, 25, 0, 0, 0, 0, 0, 0};
  int name_count [28] = '{10, 3, 0, 2, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0, 5,
    0, 3, 0, 0, 0, 0, 0, 0};
  string known_names [21] = '{"accept-ranges", "age", "allow", "cache-control", "connection",
    "content-encoding", "content-language", "content-length", "content-location",
    "content-md5", "content-range", "content-type", "date", "expires", "last-modified",
    "pragma", "server", "set-cookie", "transfer-encoding", "vary", "warning"};
  string http_tag = "http/";

  // Parser state mirrored by the predictor.
  phase_t      ph;
  int          pfx_pos;
  int          node;
  int          node_off;
  bit          name_bad;
  logic [4:0]  field;
  logic [7:0]  major_v;
  logic [7:0]  minor_v;
  logic [15:0] status_v;

  logic [7:0] pending_bytes [$];
  result_t    expected_results [$];
  int errors = 0;
  int item_count = 0;

  function automatic logic [7:0] lower(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'h20 : b;
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function automatic int dec_step(int v, logic [7:0] b, int max);
    int r;
    r = v * 10 + int'(b - "0");
    return r > max ? max : r;
  endfunction

  task automatic clear_parser();
    ph = PH_START;
    pfx_pos = 0;
    node = 0;
    node_off = 0;
    name_bad = 0;
    field = 0;
    major_v = 0;
    minor_v = 0;
    status_v = 0;
  endtask

  task automatic walk_trie(logic [7:0] ch);
    bit hit;
    string t;
    hit = 0;
    t = name_txt[node];
    if (name_bad) begin
      return;
    end
    if (node_off < t.len()) begin
      if (t[node_off] == ch) node_off++;
      else name_bad = 1;
      return;
    end
    for (int i = 0; i < name_count[node]; i++) begin
      if (!hit && name_txt[name_first[node] + i][0] == ch) begin
        node = name_first[node] + i;
        node_off = 1;
        hit = 1;
      end
    end
    if (!hit) name_bad = 1;
  endtask

  // Content byte of a header line, including the CR that closes it.
  task automatic header_content(logic [7:0] b, inout result_t r);
    if (b == ChCr) begin
      ph = PH_LINE_LF;
      if (field != 0) begin
        r.kind = KIND_HDR_END;
        r.field_code = field;
      end
    end else begin
      ph = PH_CONTENT;
      if (field != 0) begin
        r.kind = KIND_CONTENT;
        r.field_code = field;
        r.data_byte = b;
      end
    end
  endtask

  // Works out the result for one accepted byte and advances the mirrored state.
  task automatic predict_byte(logic [7:0] b, output result_t r);
    bit bad;
    bad = 0;
    r = '0;
    r.kind = KIND_CONSUMED;
    if (b == 8'h00) begin
      r.kind = (ph == PH_BODY || ph == PH_ERROR) ? KIND_DONE : KIND_ERROR;
    end else begin
      case (ph)
        PH_START: begin
          if (lower(b) == http_tag[pfx_pos]) begin
            pfx_pos++;
            if (pfx_pos == 5) begin
              pfx_pos = 0;
              ph = PH_MAJOR_START;
            end
          end else bad = 1;
        end
        PH_MAJOR_START, PH_MAJOR: begin
          if (is_num(b)) begin
            major_v = 8'(dec_step(ph == PH_MAJOR ? major_v : 0, b, 255));
            ph = PH_MAJOR;
          end else if (b == ChDot && ph == PH_MAJOR) ph = PH_MINOR_START;
          else bad = 1;
        end
        PH_MINOR_START, PH_MINOR: begin
          if (is_num(b)) begin
            minor_v = 8'(dec_step(ph == PH_MINOR ? minor_v : 0, b, 255));
            ph = PH_MINOR;
          end else if (b == ChSpace && ph == PH_MINOR) ph = PH_STATUS_START;
          else bad = 1;
        end
        PH_STATUS_START, PH_STATUS: begin
          if (is_num(b)) begin
            status_v = 16'(dec_step(ph == PH_STATUS ? status_v : 0, b, 65535));
            ph = PH_STATUS;
          end else if (b == ChSpace && ph == PH_STATUS) ph = PH_REASON_START;
          else bad = 1;
        end
        PH_REASON_START: begin
          if (is_letter(b)) ph = PH_REASON;
          else bad = 1;
        end
        PH_REASON: begin
          if (b == ChCr) ph = PH_LINE_LF;
          else if (!(is_letter(b) || b == ChSpace || b == ChDash)) bad = 1;
        end
        PH_LINE_LF: begin
          if (b == ChLf) begin
            node = 0;
            node_off = 0;
            name_bad = 0;
            field = 0;
            ph = PH_NAME;
          end else bad = 1;
        end
        PH_NAME: begin
          if (b == ChCr) begin
            ph = (node == 0 && !name_bad) ? PH_BODY_LF : PH_LINE_LF;
          end else if (b == ChColon) begin
            if (!name_bad && name_code[node] != 0 && node_off == name_txt[node].len()) begin
              field = 5'(name_code[node]);
              ph = PH_SKIPSP;
            end else begin
              field = 0;
              ph = PH_CONTENT;
            end
          end else walk_trie(lower(b));
        end
        PH_SKIPSP: begin
          if (b == ChSpace) ph = PH_CONTENT;
          else header_content(b, r);
        end
        PH_CONTENT: header_content(b, r);
        PH_BODY_LF: begin
          if (b == ChLf) ph = PH_BODY;
          else bad = 1;
        end
        PH_BODY: begin
          r.kind = KIND_BODY;
          r.data_byte = b;
        end
        default: ;
      endcase
      if (bad) begin
        r.kind = KIND_ERROR;
        ph = PH_ERROR;
      end
    end
    r.ver_major = major_v;
    r.ver_minor = minor_v;
    r.status_value = status_v;
    if (b == 8'h00) clear_parser();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Stimulus building.
  task automatic add_text(inout logic [7:0] m [$], input string s, input bit mix_case);
    for (int i = 0; i < s.len(); i++) begin
      if (mix_case && s[i] >= "a" && s[i] <= "z" && $urandom_range(0, 1)) m.push_back(s[i] - 8'h20);
      else m.push_back(s[i]);
    end
  endtask

  task automatic add_digits(inout logic [7:0] m [$], input int n);
    for (int i = 0; i < n; i++) m.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] any_but_cr();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == ChCr);
    return b;
  endfunction

  task automatic add_message(inout logic [7:0] m [$]);
    string s;
    int pick;
    add_text(m, http_tag, 1);
    add_digits(m, ($urandom_range(0, 7) == 0) ? 4 : 1);
    m.push_back(ChDot);
    add_digits(m, ($urandom_range(0, 7) == 0) ? 4 : 1);
    m.push_back(ChSpace);
    add_digits(m, ($urandom_range(0, 7) == 0) ? 6 : 3);
    m.push_back(ChSpace);
    m.push_back(8'("A" + $urandom_range(0, 25)));
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(0, 3);
      m.push_back(pick == 0 ? ChSpace : pick == 1 ? ChDash : 8'("a" + $urandom_range(0, 25)));
    end
    m.push_back(ChCr);
    m.push_back(ChLf);
    repeat ($urandom_range(0, 3)) begin
      s = known_names[$urandom_range(0, 20)];
      pick = $urandom_range(0, 9);
      if (pick == 8) s = s.substr(0, $urandom_range(0, s.len() - 2));
      if (pick == 9) s = {s, "x"};
      add_text(m, s, 1);
      if ($urandom_range(0, 9) != 0) m.push_back(ChColon);
      if ($urandom_range(0, 1)) m.push_back(ChSpace);
      repeat ($urandom_range(0, 4)) m.push_back(any_but_cr());
      m.push_back(ChCr);
      m.push_back(ChLf);
    end
    m.push_back(ChCr);
    m.push_back(ChLf);
    repeat ($urandom_range(0, 4)) m.push_back(8'($urandom_range(1, 255)));
    // Some messages get one byte corrupted.
    if ($urandom_range(0, 6) == 0) m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(0, 255));
    m.push_back(8'h00);
  endtask

  task automatic queue_bytes(logic [7:0] m [$]);
    foreach (m[i]) pending_bytes.push_back(m[i]);
    item_count += m.size();
  endtask

  // Input driver: pause before each byte, then hold valid until the transfer.
  int  send_gap = 0;
  bit  send_done = 0;
  bit  burst = 0;

  always @(posedge clk) begin
    result_t r;
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_byte(in_ch.data, r);
      expected_results.push_back(r);
      send_done = 1;
      send_gap = burst ? 0 : $urandom_range(0, 17);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= 8'h00;
    end else if (!in_ch.valid || send_done) begin
      send_done = 0;
      if ($urandom_range(0, 40) == 0) burst = !burst;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each transfer, then stall for a drawn number of cycles.
  int  recv_stall = 0;
  bit  recv_took = 0;

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = result_t'(out_ch.data);
      recv_took = 1;
      recv_stall = burst ? 0 : $urandom_range(0, 17);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer kind", got.kind, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.field_code !== want.field_code)
          report_mismatch("field_code", got.field_code, want.field_code);
        if (got.data_byte !== want.data_byte)
          report_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.ver_major !== want.ver_major)
          report_mismatch("ver_major", got.ver_major, want.ver_major);
        if (got.ver_minor !== want.ver_minor)
          report_mismatch("ver_minor", got.ver_minor, want.ver_minor);
        if (got.status_value !== want.status_value)
          report_mismatch("status_value", got.status_value, want.status_value);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (recv_took || !out_ch.ready) begin
      recv_took = 0;
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] m [$];
    clear_parser();
    in_ch.valid = 1'b0;
    in_ch.data = 8'h00;
    out_ch.ready = 1'b0;
    // Directed: mixed-case prefix, empty known header, body extremes, and
    // messages cut short or broken.
    add_text(m, "hTtP/1.1 200 OK\015\012Age:\015\012x:\015\012\015\012", 0);
    m.push_back(8'hff);
    m.push_back(8'h01);
    m.push_back(8'h00);
    add_text(m, "HTTPX", 0);
    m.push_back(8'h00);
    m.push_back(8'h00);
    queue_bytes(m);
    while (item_count < 650) begin
      m.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(1, 255)));
        m.push_back(8'h00);
      end else begin
        add_message(m);
      end
      queue_bytes(m);
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_bytes.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
